@@ rtl/core/sds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sds_pkg
// Types, tap tables and row schedule of the separable 12x12 to 8x5 weight
// downsampler.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int IN_COLS    = 12;
  localparam int OUT_COLS   = 8;
  localparam int IN_ROWS    = 12;
  localparam int SAMPLE_W   = 8;
  localparam int SUM_W      = 16;
  localparam int WEIGHT_W   = 2;
  localparam int ROW_W      = 4;
  localparam int OUT_ROW_W  = 3;
  localparam int PROD_W     = SAMPLE_W * 2 + 1;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef sample_t [IN_COLS-1:0] sample_row_t;
  typedef logic [SAMPLE_W-1:0]  hval_t;
  typedef hval_t [OUT_COLS-1:0] hval_row_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [SUM_W-1:0]     sum_t;

  typedef struct packed {
    weight_t [OUT_COLS-1:0] weight;
    logic [OUT_ROW_W-1:0]   out_row;
    logic                   block_done;
  } result_t;

  // horizontal three-tap filter, one set per output column
  localparam logic [7:0] TAP_A [OUT_COLS] = '{187, 111,  42,  90,  30,  71,  16,  68};
  localparam logic [7:0] TAP_B [OUT_COLS] = '{ 68, 128, 142, 135, 135, 142, 128, 187};
  localparam logic [7:0] TAP_C [OUT_COLS] = '{  0,  16,  71,  30,  90,  42, 111,   0};
  localparam logic [3:0] START_COL [OUT_COLS] = '{0, 1, 2, 4, 5, 7, 8, 10};

  // vertical taps per input row for the two accumulator banks
  localparam logic [7:0] VTAP_BANK0 [IN_ROWS] =
    '{134, 85, 36, 8, 42, 77, 77, 42, 8, 36, 85, 134};
  localparam logic [7:0] VTAP_BANK1 [IN_ROWS] =
    '{0, 34, 68, 85, 51, 17, 17, 51, 85, 68, 34, 0};

  // emit schedule: NO_EMIT or output row index + 1
  localparam logic [OUT_ROW_W-1:0] NO_EMIT = 3'd0;
  localparam logic [OUT_ROW_W-1:0] EMIT_CODE [IN_ROWS] =
    '{NO_EMIT, NO_EMIT, 3'd1, NO_EMIT, NO_EMIT, 3'd2,
      NO_EMIT, NO_EMIT, 3'd3, NO_EMIT, 3'd4, 3'd5};

  localparam logic [OUT_ROW_W-1:0] LAST_OUT_ROW = 3'd4;
  localparam int QUANT_SHIFT = 14;

endpackage
`default_nettype wire

@@ rtl/core/sds_hfilter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sds_hfilter
// Horizontal three-tap filter: twelve samples of one row to eight values.
// ----------------------------------------------------------------------------
module sds_hfilter import sds_pkg::*; (
  input  sample_row_t samples_i,
  output hval_row_t   hval_o
);

  sample_t px [IN_COLS+1];

  // column past the row reads as zero (its tap is zero anyway)
  always_comb begin
    for (int i = 0; i < IN_COLS; i++) begin
      px[i] = samples_i[i];
    end
    px[IN_COLS] = '0;
  end

  always_comb begin
    logic [PROD_W-1:0] acc;
    logic [3:0]        s;
    for (int c = 0; c < OUT_COLS; c++) begin
      s   = START_COL[c];
      acc = PROD_W'(TAP_A[c]) * PROD_W'(px[s])
          + PROD_W'(TAP_B[c]) * PROD_W'(px[s + 4'd1])
          + PROD_W'(TAP_C[c]) * PROD_W'(px[s + 4'd2]);
      hval_o[c] = acc[15:8];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sds_vaccum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sds_vaccum
// Vertical accumulation: row counter, two banks of eight column sums and the
// emit schedule. Offers the result row of the current input row.
// ----------------------------------------------------------------------------
module sds_vaccum import sds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  hval_row_t hval_i,
  output logic      emit_o,
  output result_t   result_o
);

  logic [ROW_W-1:0] row_q, row_d;
  sum_t             bank0_q [OUT_COLS];
  sum_t             bank1_q [OUT_COLS];
  sum_t             bank0_d [OUT_COLS];
  sum_t             bank1_d [OUT_COLS];
  sum_t             sum0 [OUT_COLS];
  sum_t             sum1 [OUT_COLS];
  logic             row_ok;
  logic [7:0]       vtap0, vtap1;
  logic [OUT_ROW_W-1:0] code, orow;
  logic             bank_sel;

  assign row_ok   = row_q < ROW_W'(IN_ROWS);
  assign vtap0    = row_ok ? VTAP_BANK0[row_q] : 8'd0;
  assign vtap1    = row_ok ? VTAP_BANK1[row_q] : 8'd0;
  assign code     = row_ok ? EMIT_CODE[row_q] : NO_EMIT;
  assign emit_o   = code != NO_EMIT;
  assign orow     = code - 3'd1;
  assign bank_sel = orow[0];

  always_comb begin
    for (int c = 0; c < OUT_COLS; c++) begin
      sum0[c] = bank0_q[c] + SUM_W'(hval_i[c]) * SUM_W'(vtap0);
      sum1[c] = bank1_q[c] + SUM_W'(hval_i[c]) * SUM_W'(vtap1);
      result_o.weight[c] = bank_sel ? sum1[c][QUANT_SHIFT +: WEIGHT_W]
                                    : sum0[c][QUANT_SHIFT +: WEIGHT_W];
      // bank restarts once its row goes out
      bank0_d[c] = (emit_o && !bank_sel) ? '0 : sum0[c];
      bank1_d[c] = (emit_o &&  bank_sel) ? '0 : sum1[c];
    end
    result_o.out_row    = orow;
    result_o.block_done = orow == LAST_OUT_ROW;
    row_d = (row_q >= ROW_W'(IN_ROWS - 1)) ? '0 : row_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      for (int c = 0; c < OUT_COLS; c++) begin
        bank0_q[c] <= '0;
        bank1_q[c] <= '0;
      end
    end else if (fire_i) begin
      row_q <= row_d;
      for (int c = 0; c < OUT_COLS; c++) begin
        bank0_q[c] <= bank0_d[c];
        bank1_q[c] <= bank1_d[c];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/separable_downsample_12x12_to_8x5.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// separable_downsample_12x12_to_8x5
// Downsamples a 12x12 grid of 8-bit weights to 8x5 grid of 2-bit weights.
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one grid row of twelve samples per request
//   (in_valid_i / in_stall_o); rows 0..11 of a grid follow each other
//   output channel carries one result row of eight weights plus out_row and
//   block_done (out_valid_o / out_stall_i); a result follows input rows
//   2, 5, 8, 10 and 11, other rows only update the column sums
//   throughput: one row per cycle unless a stalled result holds back an emitting row;
//   there are three register stages (input, horizontal filter, result)
//   a row's result passes the input, horizontal filter and result registers in turn
//   reset clears the row counter and all column sums; the block then
//   expects row 0 of a new grid
//   a stalled result holds in the output register; rows keep entering
//   until the pipeline behind a pending emit is full, then in_stall_o rises
// ----------------------------------------------------------------------------
module separable_downsample_12x12_to_8x5 import sds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] sample_0_i,
  input  logic [7:0] sample_1_i,
  input  logic [7:0] sample_2_i,
  input  logic [7:0] sample_3_i,
  input  logic [7:0] sample_4_i,
  input  logic [7:0] sample_5_i,
  input  logic [7:0] sample_6_i,
  input  logic [7:0] sample_7_i,
  input  logic [7:0] sample_8_i,
  input  logic [7:0] sample_9_i,
  input  logic [7:0] sample_10_i,
  input  logic [7:0] sample_11_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] weight_0_o,
  output logic [1:0] weight_1_o,
  output logic [1:0] weight_2_o,
  output logic [1:0] weight_3_o,
  output logic [1:0] weight_4_o,
  output logic [1:0] weight_5_o,
  output logic [1:0] weight_6_o,
  output logic [1:0] weight_7_o,
  output logic [2:0] out_row_o,
  output logic       block_done_o
);

  sample_row_t samples_d, samples_q;
  logic        in_valid_q;
  hval_row_t   hval_d, hval_q;
  logic        hval_valid_q;
  logic        out_valid_q;
  result_t     res_d, res_q;
  logic        emit;
  logic        in_ready, hval_ready, hval_fire, acc_fire, out_free;

  assign samples_d = {sample_11_i, sample_10_i, sample_9_i, sample_8_i,
                      sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                      sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  // pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign acc_fire   = hval_valid_q && (!emit || out_free);
  assign hval_ready = !hval_valid_q || acc_fire;
  assign hval_fire  = in_valid_q && hval_ready;
  assign in_ready   = !in_valid_q || hval_fire;
  assign in_stall_o = !in_ready;

  sds_hfilter u_hfilter (
    .samples_i (samples_q),
    .hval_o    (hval_d)
  );

  sds_vaccum u_vaccum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (acc_fire),
    .hval_i   (hval_q),
    .emit_o   (emit),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      hval_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (hval_ready) begin
        hval_valid_q <= in_valid_q;
      end
      if (out_free) begin
        out_valid_q <= acc_fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      samples_q <= samples_d;
    end
    if (hval_fire) begin
      hval_q <= hval_d;
    end
    if (out_free && acc_fire && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign weight_0_o   = res_q.weight[0];
  assign weight_1_o   = res_q.weight[1];
  assign weight_2_o   = res_q.weight[2];
  assign weight_3_o   = res_q.weight[3];
  assign weight_4_o   = res_q.weight[4];
  assign weight_5_o   = res_q.weight[5];
  assign weight_6_o   = res_q.weight[6];
  assign weight_7_o   = res_q.weight[7];
  assign out_row_o    = res_q.out_row;
  assign block_done_o = res_q.block_done;

  // input side stalls only with a row held in the input register
  a_stall_needs_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stall without a held row");

  // a pending emit never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && hval_valid_q && emit) |-> !acc_fire)
    else $error("result overwritten while stalled");

  // last output row of a grid is exactly the one flagged done
  a_done_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (block_done_o == (out_row_o == LAST_OUT_ROW)))
    else $error("block_done does not match out_row");

  // a result row shows up only after a row left the accumulate stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(acc_fire && emit))
    else $error("result without an emitting row");

endmodule
`default_nettype wire

@@ dv/downsample_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// downsample_checker
// Watches both channels of the 12x12 to 8x5 weight downsampler, predicts
// each result row from the accepted input rows and compares it field by
// field against what the block sends.
// ----------------------------------------------------------------------------
module downsample_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [11:0][7:0] samples_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [7:0][1:0]  weights_i,
  input  logic [2:0]       out_row_i,
  input  logic             block_done_i,
  output int unsigned      outstanding_o,
  output int unsigned      errors_o,
  output int unsigned      checked_o
);

  // horizontal taps and start columns, one entry per output column
  localparam logic [0:7][7:0] LEFT_TAP  = {8'd187, 8'd111, 8'd42, 8'd90,
                                           8'd30, 8'd71, 8'd16, 8'd68};
  localparam logic [0:7][7:0] MID_TAP   = {8'd68, 8'd128, 8'd142, 8'd135,
                                           8'd135, 8'd142, 8'd128, 8'd187};
  localparam logic [0:7][7:0] RIGHT_TAP = {8'd0, 8'd16, 8'd71, 8'd30,
                                           8'd90, 8'd42, 8'd111, 8'd0};
  localparam logic [0:7][3:0] START_COL = {4'd0, 4'd1, 4'd2, 4'd4,
                                           4'd5, 4'd7, 4'd8, 4'd10};

  // vertical taps per input row
  localparam logic [0:11][7:0] EVEN_BANK_TAP = {8'd134, 8'd85, 8'd36, 8'd8, 8'd42, 8'd77,
                                                8'd77, 8'd42, 8'd8, 8'd36, 8'd85, 8'd134};
  localparam logic [0:11][7:0] ODD_BANK_TAP  = {8'd0, 8'd34, 8'd68, 8'd85, 8'd51, 8'd17,
                                                8'd17, 8'd51, 8'd85, 8'd68, 8'd34, 8'd0};

  localparam logic [2:0] NO_ROW   = 3'd7;
  localparam logic [2:0] LAST_ROW = 3'd4;
  localparam logic [3:0] FINAL_INPUT_ROW = 4'd11;

  // output row finished by each input row
  localparam logic [0:11][2:0] EMITTED_ROW = {NO_ROW, NO_ROW, 3'd0, NO_ROW, NO_ROW, 3'd1,
                                              NO_ROW, NO_ROW, 3'd2, NO_ROW, 3'd3, 3'd4};

  typedef struct packed {
    logic [7:0][1:0] weight;
    logic [2:0]      out_row;
    logic            block_done;
  } coarse_row_t;

  coarse_row_t coarse_rows_q[$];
  logic [15:0] col_sum [2][8];
  logic [3:0]  grid_row;
  int unsigned errors;
  int unsigned checked;

  task automatic fold_in_row(input logic [11:0][7:0] row);
    logic [7:0]  px [13];
    logic [16:0] acc;
    logic [7:0]  hval;
    logic [3:0]  s;
    logic [2:0]  orow;
    coarse_row_t res;
    for (int c = 0; c < 12; c++) px[c] = row[c];
    // third tap of the last column lands past the row
    px[12] = 8'd0;
    for (int c = 0; c < 8; c++) begin
      s = START_COL[c];
      acc = LEFT_TAP[c] * px[s] + MID_TAP[c] * px[s + 1] + RIGHT_TAP[c] * px[s + 2];
      hval = acc[15:8];
      col_sum[0][c] = col_sum[0][c] + hval * EVEN_BANK_TAP[grid_row];
      col_sum[1][c] = col_sum[1][c] + hval * ODD_BANK_TAP[grid_row];
    end
    orow = EMITTED_ROW[grid_row];
    if (orow != NO_ROW) begin
      for (int c = 0; c < 8; c++) begin
        res.weight[c] = col_sum[orow[0]][c][15:14];
        col_sum[orow[0]][c] = '0;
      end
      res.out_row = orow;
      res.block_done = (orow == LAST_ROW);
      coarse_rows_q.push_back(res);
    end
    grid_row = (grid_row == FINAL_INPUT_ROW) ? 4'd0 : grid_row + 4'd1;
  endtask

  task automatic check_result();
    coarse_row_t want;
    if (coarse_rows_q.size() == 0) begin
      $error("result row %0d arrived with nothing expected", out_row_i);
      errors++;
    end else begin
      want = coarse_rows_q.pop_front();
      checked++;
      for (int c = 0; c < 8; c++) begin
        if (weights_i[c] !== want.weight[c]) begin
          $error("weight_%0d: expected %0d, got %0d", c, want.weight[c], weights_i[c]);
          errors++;
        end
      end
      if (out_row_i !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, out_row_i);
        errors++;
      end
      if (block_done_i !== want.block_done) begin
        $error("block_done: expected %0d, got %0d", want.block_done, block_done_i);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_row = 4'd0;
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 8; c++) col_sum[b][c] = '0;
      coarse_rows_q.delete();
      errors = 0;
      checked = 0;
      outstanding_o <= 0;
      errors_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) fold_in_row(samples_i);
      outstanding_o <= coarse_rows_q.size();
      errors_o <= errors;
      checked_o <= checked;
    end
  end

endmodule

@@ dv/tb_separable_downsample_12x12_to_8x5.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_separable_downsample_12x12_to_8x5
// Feeds grid rows into the weight downsampler with random gaps and random
// result stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_separable_downsample_12x12_to_8x5;

  localparam int RANDOM_ROWS = 1250;
  localparam int MID_DRAIN   = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 10;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             out_stall = 1'b0;
  logic [11:0][7:0] samples = '0;
  logic             in_stall;
  logic             out_valid;
  wire  [7:0][1:0]  weights;
  wire  [2:0]       out_row;
  wire              block_done;

  int unsigned outstanding;
  int unsigned errors;
  int unsigned checked;
  int unsigned rows_sent = 0;
  int unsigned cycles = 0;
  bit          send_quiet = 1'b0;

  always #4 clk = ~clk;

  separable_downsample_12x12_to_8x5 uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_0_i   (samples[0]),
    .sample_1_i   (samples[1]),
    .sample_2_i   (samples[2]),
    .sample_3_i   (samples[3]),
    .sample_4_i   (samples[4]),
    .sample_5_i   (samples[5]),
    .sample_6_i   (samples[6]),
    .sample_7_i   (samples[7]),
    .sample_8_i   (samples[8]),
    .sample_9_i   (samples[9]),
    .sample_10_i  (samples[10]),
    .sample_11_i  (samples[11]),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .weight_0_o   (weights[0]),
    .weight_1_o   (weights[1]),
    .weight_2_o   (weights[2]),
    .weight_3_o   (weights[3]),
    .weight_4_o   (weights[4]),
    .weight_5_o   (weights[5]),
    .weight_6_o   (weights[6]),
    .weight_7_o   (weights[7]),
    .out_row_o    (out_row),
    .block_done_o (block_done)
  );

  downsample_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .samples_i     (samples),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .weights_i     (weights),
    .out_row_i     (out_row),
    .block_done_i  (block_done),
    .outstanding_o (outstanding),
    .errors_o      (errors),
    .checked_o     (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result rows still expected", cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_row(input logic [11:0][7:0] row);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples <= row;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    rows_sent++;
  endtask

  // hold off new requests until every pending result row is out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [11:0][7:0] random_row();
    logic [11:0][7:0] row;
    int unsigned      mode;
    mode = $urandom_range(0, 9);
    for (int c = 0; c < 12; c++) begin
      case (mode)
        6: row[c] = 8'hff;
        7: row[c] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        8: row[c] = $urandom_range(192, 255);
        9: row[c] = $urandom_range(0, 63);
        default: row[c] = $urandom_range(0, 255);
      endcase
    end
    return row;
  endfunction

  // result side: random stall before each result row, with quiet stretches
  initial begin
    int unsigned hold;
    int unsigned taken;
    bit          quiet;
    taken = 0;
    quiet = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (taken % 24 == 0) quiet = ($urandom_range(0, 3) == 0);
      hold = quiet ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one grid at full scale, one grid of zeros
    for (int i = 0; i < 12; i++) send_row({12{8'hff}});
    for (int i = 0; i < 12; i++) send_row({12{8'h00}});
    drain();

    for (int i = 0; i < RANDOM_ROWS; i++) begin
      if (i % 32 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (i == MID_DRAIN) drain();
      send_row(random_row());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);

    $display("%0d rows sent (%0d full grids), %0d result rows checked", rows_sent,
             rows_sent / 12, checked);
    $display("gaps of 0..11 cycles on both channels, two full drains mid-run");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
